// File: hdl/gjk_lc_pkg.sv
`default_nettype none

package gjk_lc_pkg;

  // Field and intermediate widths; every product is kept exact.
  localparam int CoordW   = 16;  // Q8.8 input coordinate
  localparam int VecW     = 17;  // AB = B - A and AO = -A
  localparam int ProdW    = 34;  // one VecW x VecW product
  localparam int DotW     = 36;  // sum of three products
  localparam int CrossW   = 35;  // one component of AB x AO
  localparam int DirProdW = 52;  // CrossW x VecW product
  localparam int DirSumW  = 53;  // one component of (AB x AO) x AB
  localparam int DirW     = 50;  // Q26.24 output component
  localparam int FracW    = 16;  // shift from Q8.8 to Q26.24

  // Rank codes.
  localparam logic [1:0] RankA  = 2'd1;
  localparam logic [1:0] RankAB = 2'd2;

  typedef logic [2:0][VecW-1:0]   vec_t;
  typedef logic [2:0][CrossW-1:0] cross_t;

  // Request state after the first product stages.
  typedef struct packed {
    logic   dot_neg;
    vec_t   ab;
    vec_t   ao;
    cross_t c;
  } gjk_lc_mid_t;

  // Sign-extend a Q9.8 vector component and move it to Q26.24.
  function automatic logic [DirW-1:0] scale_vec(input logic [VecW-1:0] v);
    scale_vec = {{(DirW - VecW - FracW){v[VecW-1]}}, v, {FracW{1'b0}}};
  endfunction

  // Clamp an exact triple-product component to the output range.
  function automatic logic [DirW-1:0] sat_dir(input logic [DirSumW-1:0] v);
    logic [DirSumW-DirW:0] top;
    top = v[DirSumW-1:DirW-1];
    if (top == '0 || top == '1) begin
      sat_dir = v[DirW-1:0];
    end else if (v[DirSumW-1]) begin
      sat_dir = {1'b1, {(DirW-1){1'b0}}};
    end else begin
      sat_dir = {1'b0, {(DirW-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/gjk_lc_if.sv
`default_nettype none

// Input channel: the two newest simplex points.
interface gjk_lc_in_if;
  import gjk_lc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] a_x;
  logic [CoordW-1:0] a_y;
  logic [CoordW-1:0] a_z;
  logic [CoordW-1:0] b_x;
  logic [CoordW-1:0] b_y;
  logic [CoordW-1:0] b_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

// Result channel: kept rank and new search direction.
interface gjk_lc_out_if;
  import gjk_lc_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      rank;
  logic [DirW-1:0] dir_x;
  logic [DirW-1:0] dir_y;
  logic [DirW-1:0] dir_z;

  modport source (output valid, rank, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, rank, dir_x, dir_y, dir_z, output ready);
endinterface

`default_nettype wire

// File: hdl/gjk_line_case_direction_top.sv
`default_nettype none

// GJK line case: from the newest point A and the older point B (signed Q8.8)
// the block returns the rank kept (1 or 2) and the next search direction in
// signed Q26.24, either (AB x AO) x AB clamped to 50 bits, AB crossed with its
// smallest axis when that triple product is zero, or AO when the origin lies
// behind A. It takes one request per cycle while the result side does not
// stall, and presents each result through five register stages, the first
// loaded at the accepting edge; the depth comes from the edge-vector
// subtraction and the two chained multiplier levels (AB x AO, then the cross
// with AB), each followed by its own adder stage. Stalls on the result side
// back up stage by stage, and empty stages keep taking requests.
module gjk_line_case_direction_top import gjk_lc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  gjk_lc_in_if.sink     in_chan,
  gjk_lc_out_if.source  out_chan
);

  logic        mid_valid;
  logic        mid_ready;
  gjk_lc_mid_t mid;

  // Edge vectors, dot sign and AB x AO.
  gjk_lc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid)
  );

  // Triple product, fallback and output register.
  gjk_lc_dir u_dir (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid       (mid),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

// File: hdl/gjk_lc_prep.sv
`default_nettype none

// Stages 1 to 3: edge vectors, first products, dot sign and AB x AO.
module gjk_lc_prep import gjk_lc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gjk_lc_in_if.sink   in_chan,
  output logic        mid_valid,
  input  wire logic   mid_ready,
  output gjk_lc_mid_t mid
);

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  vec_t ab1_r, ab1_nxt, ao1_r, ao1_nxt;
  vec_t ab2_r, ao2_r;
  logic [2:0][ProdW-1:0] pd2_r, pd2_nxt, pa2_r, pa2_nxt, pb2_r, pb2_nxt;
  gjk_lc_mid_t s3_r, s3_nxt;
  logic [DotW-1:0] dot;

  logic signed [CoordW-1:0] a_s [3];
  logic signed [CoordW-1:0] b_s [3];

  // A stage takes a new request when it is empty or its contents move on.
  assign rdy3          = !v3_r || mid_ready;
  assign rdy2          = !v2_r || rdy3;
  assign rdy1          = !v1_r || rdy2;
  assign in_chan.ready = rdy1;

  // Stage 1: AB = B - A and AO = -A.
  always_comb begin
    a_s[0] = in_chan.a_x;
    a_s[1] = in_chan.a_y;
    a_s[2] = in_chan.a_z;
    b_s[0] = in_chan.b_x;
    b_s[1] = in_chan.b_y;
    b_s[2] = in_chan.b_z;
    for (int i = 0; i < 3; i++) begin
      ab1_nxt[i] = VecW'(b_s[i]) - VecW'(a_s[i]);
      ao1_nxt[i] = -VecW'(a_s[i]);
    end
  end

  // Stage 2: products for the dot product and for AB x AO.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd2_nxt[i] = ProdW'($signed(ab1_r[i])) * ProdW'($signed(ao1_r[i]));
    end
    pa2_nxt[0] = ProdW'($signed(ab1_r[1])) * ProdW'($signed(ao1_r[2]));
    pb2_nxt[0] = ProdW'($signed(ab1_r[2])) * ProdW'($signed(ao1_r[1]));
    pa2_nxt[1] = ProdW'($signed(ab1_r[2])) * ProdW'($signed(ao1_r[0]));
    pb2_nxt[1] = ProdW'($signed(ab1_r[0])) * ProdW'($signed(ao1_r[2]));
    pa2_nxt[2] = ProdW'($signed(ab1_r[0])) * ProdW'($signed(ao1_r[1]));
    pb2_nxt[2] = ProdW'($signed(ab1_r[1])) * ProdW'($signed(ao1_r[0]));
  end

  // Stage 3: sum the dot product and form the cross product.
  always_comb begin
    dot = DotW'($signed(pd2_r[0])) + DotW'($signed(pd2_r[1])) +
          DotW'($signed(pd2_r[2]));
    s3_nxt.dot_neg = dot[DotW-1];
    s3_nxt.ab      = ab2_r;
    s3_nxt.ao      = ao2_r;
    for (int i = 0; i < 3; i++) begin
      s3_nxt.c[i] = CrossW'($signed(pa2_r[i])) - CrossW'($signed(pb2_r[i]));
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_chan.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      ab1_r <= ab1_nxt;
      ao1_r <= ao1_nxt;
    end
    if (rdy2) begin
      ab2_r <= ab1_r;
      ao2_r <= ao1_r;
      pd2_r <= pd2_nxt;
      pa2_r <= pa2_nxt;
      pb2_r <= pb2_nxt;
    end
    if (rdy3) begin
      s3_r <= s3_nxt;
    end
  end

  assign mid_valid = v3_r;
  assign mid       = s3_r;

  // A stalled request at the stage output stays put.
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !mid_ready |=> v3_r && $stable(s3_r))
    else $error("stage 3 request changed while stalled");

  // A negative dot product needs A away from the origin.
  a_neg_dot: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && s3_r.dot_neg |-> s3_r.ao != '0)
    else $error("negative dot product with A at the origin");

endmodule

`default_nettype wire

// File: hdl/gjk_lc_dir.sv
`default_nettype none

// Stages 4 and 5: triple product, fallback axis cross, selection and clamp.
module gjk_lc_dir import gjk_lc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         mid_valid,
  output logic              mid_ready,
  input  wire gjk_lc_mid_t  mid,
  gjk_lc_out_if.source      out_chan
);

  logic v4_r, v5_r;
  logic rdy4, rdy5;

  logic [2:0][DirProdW-1:0] pa4_r, pa4_nxt, pb4_r, pb4_nxt;
  vec_t fb4_r, fb4_nxt, ao4_r;
  logic dneg4_r;

  logic [VecW-2:0] abs_x, abs_y, abs_z;
  vec_t nab;

  logic [2:0][DirSumW-1:0] d5;
  logic                    d5_zero;
  logic [1:0]              rank5_r, rank5_nxt;
  logic [2:0][DirW-1:0]    dir5_r, dir5_nxt;

  assign rdy5      = !v5_r || out_chan.ready;
  assign rdy4      = !v4_r || rdy5;
  assign mid_ready = rdy4;

  // Stage 4 products of (AB x AO) x AB; the operands are sign-extended
  // CrossW by VecW values.
  always_comb begin
    pa4_nxt[0] = DirProdW'($signed(mid.c[1])) * DirProdW'($signed(mid.ab[2]));
    pb4_nxt[0] = DirProdW'($signed(mid.c[2])) * DirProdW'($signed(mid.ab[1]));
    pa4_nxt[1] = DirProdW'($signed(mid.c[2])) * DirProdW'($signed(mid.ab[0]));
    pb4_nxt[1] = DirProdW'($signed(mid.c[0])) * DirProdW'($signed(mid.ab[2]));
    pa4_nxt[2] = DirProdW'($signed(mid.c[0])) * DirProdW'($signed(mid.ab[1]));
    pb4_nxt[2] = DirProdW'($signed(mid.c[1])) * DirProdW'($signed(mid.ab[0]));
  end

  // Stage 4 fallback: AB crossed with its smallest axis, ties to x then y,
  // and AB x z when that cross vanishes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nab[i] = -$signed(mid.ab[i]);
    end
    abs_x = mid.ab[0][VecW-1] ? nab[0][VecW-2:0] : mid.ab[0][VecW-2:0];
    abs_y = mid.ab[1][VecW-1] ? nab[1][VecW-2:0] : mid.ab[1][VecW-2:0];
    abs_z = mid.ab[2][VecW-1] ? nab[2][VecW-2:0] : mid.ab[2][VecW-2:0];
    if (abs_x <= abs_y && abs_x <= abs_z) begin
      fb4_nxt = {nab[1], mid.ab[2], {VecW{1'b0}}};
    end else if (abs_y <= abs_z) begin
      fb4_nxt = {mid.ab[0], {VecW{1'b0}}, nab[2]};
    end else begin
      fb4_nxt = {{VecW{1'b0}}, nab[0], mid.ab[1]};
    end
    if (fb4_nxt == '0) begin
      fb4_nxt = {{VecW{1'b0}}, nab[0], mid.ab[1]};
    end
  end

  // Stage 5: finish the triple product and pick the direction.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d5[i] = DirSumW'($signed(pa4_r[i])) - DirSumW'($signed(pb4_r[i]));
    end
    d5_zero = (d5 == '0);
    for (int i = 0; i < 3; i++) begin
      if (dneg4_r) begin
        dir5_nxt[i] = scale_vec(ao4_r[i]);
      end else if (d5_zero) begin
        dir5_nxt[i] = scale_vec(fb4_r[i]);
      end else begin
        dir5_nxt[i] = sat_dir(d5[i]);
      end
    end
    rank5_nxt = dneg4_r ? RankA : RankAB;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_r <= mid_valid;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rdy4) begin
      pa4_r   <= pa4_nxt;
      pb4_r   <= pb4_nxt;
      fb4_r   <= fb4_nxt;
      ao4_r   <= mid.ao;
      dneg4_r <= mid.dot_neg;
    end
    if (rdy5) begin
      rank5_r <= rank5_nxt;
      dir5_r  <= dir5_nxt;
    end
  end

  assign out_chan.valid = v5_r;
  assign out_chan.rank  = rank5_r;
  assign out_chan.dir_x = dir5_r[0];
  assign out_chan.dir_y = dir5_r[1];
  assign out_chan.dir_z = dir5_r[2];

  // Rank one returns AO, which is a whole Q8.8 value shifted up.
  a_rank_a_frac: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && rank5_r == RankA |->
      dir5_r[0][FracW-1:0] == '0 && dir5_r[1][FracW-1:0] == '0 &&
      dir5_r[2][FracW-1:0] == '0)
    else $error("rank one direction has fraction bits set");

  // Rank one only occurs with A off the origin, so AO is never zero.
  a_rank_a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && rank5_r == RankA |-> dir5_r != '0)
    else $error("rank one direction is the zero vector");

endmodule

`default_nettype wire
